// ===== rtl/rtp_sequence_reorder_buffer_defines.svh =====
// ----------------------------------------------------------------------------
// RTP sequence reorder buffer: assertion macros
// Shared property shorthands for the reorder buffer RTL.
// ----------------------------------------------------------------------------
`ifndef RTP_SEQUENCE_REORDER_BUFFER_DEFINES_SVH
`define RTP_SEQUENCE_REORDER_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define RSRB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RSRB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rtpsrb_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpsrb_pkg
// Types and constants shared by the RTP reorder buffer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package rtpsrb_pkg;

  localparam int unsigned MaxWindowDef = 32;
  localparam int unsigned MaxRecords   = 36;

  localparam logic [6:0]  PtReset    = 7'd96;
  localparam logic [5:0]  WinReset   = 6'd16;
  localparam logic [31:0] DelayReset = 32'd1000;

  typedef enum logic [1:0] {
    KIND_PKT   = 2'd0,
    KIND_TICK  = 2'd1,
    KIND_RESET = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REC_RELEASE = 3'd0,
    REC_DISC    = 3'd1,
    REC_DUP     = 3'd2,
    REC_CFG_ERR = 3'd3,
    REC_NONE    = 3'd4
  } rec_type_e;

  typedef enum logic [1:0] {
    RSN_PT   = 2'd0,
    RSN_SSRC = 2'd1,
    RSN_GAP  = 2'd2
  } reason_e;

  typedef enum logic [1:0] {
    CFG_PT    = 2'd0,
    CFG_WIN   = 2'd1,
    CFG_DELAY = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] seq;
    logic [15:0] handle;
    logic [47:0] arrival;
  } entry_t;

  // controls common to every cell of the ring
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic [2:0]  rtype;
    logic [1:0]  reason;
    logic [15:0] first_seq;
    logic [15:0] last_seq;
    logic [15:0] handle;
    logic        tlast;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/rtpsrb_cell.sv =====
// ----------------------------------------------------------------------------
// rtpsrb_cell
// One held-packet slot of the ring; shifts to its neighbor while scanning.
// ----------------------------------------------------------------------------
`default_nettype none

module rtpsrb_cell import rtpsrb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctl_t   ctl_i,
  input  logic        ins_i,
  input  logic        kill_i,
  input  entry_t      ins_ent_i,
  input  logic        nb_valid_i,
  input  entry_t      nb_ent_i,
  input  logic [15:0] exp_seq_i,
  input  logic [15:0] pkt_seq_i,
  output logic        valid_o,
  output entry_t      ent_o,
  output logic        hit_exp_o,
  output logic        hit_pkt_o
);

  logic   valid_q;
  entry_t ent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clear || kill_i) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= nb_valid_i;
    end else if (ins_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      ent_q <= nb_ent_i;
    end else if (ins_i) begin
      ent_q <= ins_ent_i;
    end
  end

  assign valid_o   = valid_q;
  assign ent_o     = ent_q;
  assign hit_exp_o = valid_q && (ent_q.seq == exp_seq_i);
  assign hit_pkt_o = valid_q && (ent_q.seq == pkt_seq_i);

endmodule

`default_nettype wire

// ===== rtl/rtp_sequence_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// rtp_sequence_reorder_buffer
// Holds RTP packets in a ring of cells and releases them in sequence order.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one beat per item; tuser = kind, tdata = packet fields and time.
//   m_axis: one beat per record; tuser = record type, tlast marks the final
//   record of an item. Every item yields at least one record.
//   cfg: register writes (index, data), always ready; write only while idle.
// Timing: one item at a time. s_axis_tready is high only when the block
//   is idle. A packet that leaves entries held runs one ring scan for the
//   deadline check. A window gap adds a second scan, and each gap adds
//   its drain. A packet that empties the table skips the scan. The scans
//   rotate the whole ring past its head cell, one cell a cycle.
// Records leave through a one-record hold stage and an output register;
// when the receiver stalls, the block holds in place until the output frees.
// Reset: table empty, expected/source unknown, registers at reset values.
// ----------------------------------------------------------------------------
`default_nettype none
`include "rtp_sequence_reorder_buffer_defines.svh"

module rtp_sequence_reorder_buffer import rtpsrb_pkg::*; #(
  parameter int unsigned MAX_WINDOW = MaxWindowDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] sequence_number, [47:16] stream_source_id, [54:48] payload_type_in,
  // [70:55] packet_handle, [118:71] now_ticks, [119] zero
  input  logic [119:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [1:0] reason, [17:2] first_sequence, [33:18] last_sequence,
  // [49:34] released_handle, [55:50] zero
  output logic [55:0]  m_axis_tdata,
  // [2:0] record_type
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  localparam int unsigned Slots = MAX_WINDOW + 1;
  localparam int unsigned CntW  = $clog2(Slots + 1);
  localparam int unsigned ScanW = $clog2(Slots);
  localparam int unsigned RecW  = $clog2(MaxRecords + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_PKT, ST_DRAIN, ST_WIN, ST_DL, ST_SCAN, ST_GAP, ST_FLUSH
  } state_e;

  typedef enum logic [1:0] {PH_WIN, PH_DL, PH_END} phase_e;

  function automatic rec_t mk_rec(rec_type_e t, reason_e r, logic [15:0] f,
                                  logic [15:0] l, logic [15:0] h);
    rec_t rc;
    rc.rtype     = t;
    rc.reason    = r;
    rc.first_seq = f;
    rc.last_seq  = l;
    rc.handle    = h;
    rc.tlast     = 1'b0;
    return rc;
  endfunction

  // control and configuration
  state_e       st_q, st_d;
  phase_e       ph_q, ph_d;
  logic [6:0]   pt_cfg_q, pt_cfg_d;
  logic [5:0]   win_q, win_d;
  logic [31:0]  delay_q, delay_d;
  // latched item
  kind_e        kind_q, kind_d;
  logic [15:0]  seq_q, seq_d;
  logic [31:0]  ssrc_q, ssrc_d;
  logic [6:0]   pt_q, pt_d;
  logic [15:0]  hdl_q, hdl_d;
  logic [47:0]  now_q, now_d;
  // stream state
  logic [15:0]  exp_q, exp_d;
  logic         exp_known_q, exp_known_d;
  logic [31:0]  src_q, src_d;
  logic         src_known_q, src_known_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  // scan results
  logic [ScanW-1:0] scan_q, scan_d;
  logic         scan_win_q, scan_win_d;
  logic         have_q, have_d;
  logic signed [15:0] best_q, best_d;
  logic [15:0]  near_q, near_d;
  logic [47:0]  oldest_q, oldest_d;
  // record path
  logic [RecW-1:0] rcnt_q, rcnt_d;
  rec_t         pend_q, pend_d, out_q, out_d;
  logic         pend_v_q, pend_v_d, out_v_q, out_v_d;

  // ring
  cell_ctl_t    ctl;
  logic [Slots-1:0] vld, hit_exp, hit_pkt, kill, ins_oh, free;
  entry_t       ent [Slots];
  entry_t       ins_ent;

  logic         emit;
  logic         store;
  rec_t         erec;
  logic         out_free, can_emit, cfg_bad, over_win, fire;
  logic [7:0]   win_eff;
  logic [15:0]  rel_handle;
  logic signed [15:0] pkt_dist, head_dist;
  logic [48:0]  due;

  assign free    = ~vld;
  assign ins_oh  = free & (~free + Slots'(1));
  assign ins_ent = '{seq: seq_q, handle: hdl_q, arrival: now_q};

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    localparam int unsigned Nb = (i + 1) % Slots;
    rtpsrb_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .ins_i      (ins_oh[i] && store),
      .kill_i     (kill[i]),
      .ins_ent_i  (ins_ent),
      .nb_valid_i (vld[Nb]),
      .nb_ent_i   (ent[Nb]),
      .exp_seq_i  (exp_q),
      .pkt_seq_i  (seq_q),
      .valid_o    (vld[i]),
      .ent_o      (ent[i]),
      .hit_exp_o  (hit_exp[i]),
      .hit_pkt_o  (hit_pkt[i])
    );
  end

  // matching entries are unique, so an OR picks the released handle
  always_comb begin
    rel_handle = '0;
    for (int i = 0; i < Slots; i++) begin
      if (hit_exp[i]) rel_handle = rel_handle | ent[i].handle;
    end
  end

  assign out_free  = !out_v_q || m_axis_tready;
  assign can_emit  = !pend_v_q || out_free;
  assign cfg_bad   = (win_q == '0) || (delay_q == '0);
  assign win_eff   = (8'(win_q) > 8'(MAX_WINDOW)) ? 8'(MAX_WINDOW) : 8'(win_q);
  assign over_win  = 8'(cnt_q) > win_eff;
  assign pkt_dist  = signed'(seq_q - exp_q);
  assign head_dist = signed'(ent[0].seq - exp_q);
  assign due       = {1'b0, oldest_q} + 49'(delay_q);
  assign fire      = scan_win_q || (have_q && ({1'b0, now_q} >= due));

  always_comb begin
    st_d = st_q; ph_d = ph_q;
    pt_cfg_d = pt_cfg_q; win_d = win_q; delay_d = delay_q;
    kind_d = kind_q; seq_d = seq_q; ssrc_d = ssrc_q; pt_d = pt_q;
    hdl_d = hdl_q; now_d = now_q;
    exp_d = exp_q; exp_known_d = exp_known_q; src_d = src_q; src_known_d = src_known_q;
    cnt_d = cnt_q;
    scan_d = scan_q; scan_win_d = scan_win_q; have_d = have_q;
    best_d = best_q; near_d = near_q; oldest_d = oldest_q;
    rcnt_d = rcnt_q; pend_d = pend_q; pend_v_d = pend_v_q;
    out_d = out_q; out_v_d = out_v_q && !m_axis_tready;
    ctl = '0; kill = '0;
    emit = 1'b0;
    store = 1'b0;
    erec = mk_rec(REC_NONE, RSN_PT, '0, '0, '0);

    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_PT:    pt_cfg_d = cfg_data_i[6:0];
        CFG_WIN:   win_d    = cfg_data_i[5:0];
        CFG_DELAY: delay_d  = cfg_data_i;
        default: ;
      endcase
    end

    unique case (st_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          kind_d = kind_e'(s_axis_tuser);
          seq_d  = s_axis_tdata[15:0];
          ssrc_d = s_axis_tdata[47:16];
          pt_d   = s_axis_tdata[54:48];
          hdl_d  = s_axis_tdata[70:55];
          now_d  = s_axis_tdata[118:71];
          rcnt_d = '0;
          st_d   = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (kind_q)
          KIND_PKT: begin
            if (cfg_bad) begin
              emit = 1'b1;
              erec = mk_rec(REC_CFG_ERR, RSN_PT, '0, '0, '0);
              st_d = ST_FLUSH;
            end else if (pt_q != pt_cfg_q) begin
              emit = 1'b1;
              erec = mk_rec(REC_DISC, RSN_PT, seq_q, seq_q, '0);
              st_d = ST_FLUSH;
            end else begin
              // new source: report, drop the table and resync
              if (src_known_q && (src_q != ssrc_q)) begin
                emit        = 1'b1;
                erec        = mk_rec(REC_DISC, RSN_SSRC, seq_q, seq_q, '0);
                exp_d       = seq_q;
                exp_known_d = 1'b1;
                ctl.clear   = 1'b1;
                cnt_d       = '0;
              end else if (!exp_known_q) begin
                exp_d       = seq_q;
                exp_known_d = 1'b1;
              end
              src_d       = ssrc_q;
              src_known_d = 1'b1;
              st_d        = ST_PKT;
            end
          end
          KIND_TICK: begin
            if (cfg_bad) begin
              emit = 1'b1;
              erec = mk_rec(REC_CFG_ERR, RSN_PT, '0, '0, '0);
              st_d = ST_FLUSH;
            end else begin
              st_d = ST_DL;
            end
          end
          KIND_RESET: begin
            ctl.clear   = 1'b1;
            cnt_d       = '0;
            exp_d       = '0;
            exp_known_d = 1'b0;
            src_d       = '0;
            src_known_d = 1'b0;
            st_d        = ST_FLUSH;
          end
          default: st_d = ST_FLUSH;
        endcase
      end
      ST_PKT: begin
        if (pkt_dist < 0 || (|hit_pkt)) begin
          if (can_emit) begin
            emit = 1'b1;
            erec = mk_rec(REC_DUP, RSN_PT, seq_q, seq_q, '0);
            st_d = ST_FLUSH;
          end
        end else begin
          // store into the lowest free cell
          store = 1'b1;
          if (|free) cnt_d = cnt_q + CntW'(1);
          ph_d = PH_WIN;
          st_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (exp_known_q && (|hit_exp)) begin
          if (can_emit) begin
            emit  = 1'b1;
            erec  = mk_rec(REC_RELEASE, RSN_PT, exp_q, exp_q, rel_handle);
            kill  = hit_exp;
            exp_d = exp_q + 16'd1;
            cnt_d = cnt_q - CntW'(1);
          end
        end else begin
          unique case (ph_q)
            PH_WIN:  st_d = ST_WIN;
            PH_DL:   st_d = ST_DL;
            default: st_d = ST_FLUSH;
          endcase
        end
      end
      ST_WIN: begin
        if (over_win) begin
          scan_d = '0; have_d = 1'b0; scan_win_d = 1'b1;
          st_d   = ST_SCAN;
        end else begin
          st_d = ST_DL;
        end
      end
      ST_DL: begin
        if (exp_known_q && (cnt_q != '0)) begin
          scan_d = '0; have_d = 1'b0; scan_win_d = 1'b0;
          st_d   = ST_SCAN;
        end else begin
          st_d = ST_FLUSH;
        end
      end
      ST_SCAN: begin
        // look at the head cell, then rotate the ring by one
        if (vld[0]) begin
          if (!have_q || head_dist < best_q) begin
            best_d = head_dist;
            near_d = ent[0].seq;
          end
          if (!have_q || ent[0].arrival < oldest_q) oldest_d = ent[0].arrival;
          have_d = 1'b1;
        end
        ctl.shift = 1'b1;
        scan_d    = scan_q + ScanW'(1);
        if (scan_q == ScanW'(Slots - 1)) st_d = ST_GAP;
      end
      ST_GAP: begin
        if (fire) begin
          if (can_emit) begin
            emit  = 1'b1;
            erec  = mk_rec(REC_DISC, RSN_GAP, exp_q, near_q, '0);
            exp_d = near_q;
            ph_d  = scan_win_q ? PH_DL : PH_END;
            st_d  = ST_DRAIN;
          end
        end else begin
          st_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!pend_v_q) begin
          pend_d   = mk_rec(REC_NONE, RSN_PT, '0, '0, '0);
          pend_v_d = 1'b1;
        end else if (out_free) begin
          out_d       = pend_q;
          out_d.tlast = 1'b1;
          out_v_d     = 1'b1;
          pend_v_d    = 1'b0;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase

    // hold stage: the previous record moves on once a newer one exists
    if (emit && (rcnt_q < RecW'(MaxRecords))) begin
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = erec;
      pend_v_d = 1'b1;
      rcnt_d   = rcnt_q + RecW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ph_q <= PH_WIN;
      pt_cfg_q <= PtReset; win_q <= WinReset; delay_q <= DelayReset;
      kind_q <= KIND_NONE; seq_q <= '0; ssrc_q <= '0; pt_q <= '0;
      hdl_q <= '0; now_q <= '0;
      exp_q <= '0; exp_known_q <= 1'b0; src_q <= '0; src_known_q <= 1'b0;
      cnt_q <= '0;
      scan_q <= '0; scan_win_q <= 1'b0; have_q <= 1'b0;
      best_q <= '0; near_q <= '0; oldest_q <= '0;
      rcnt_q <= '0; pend_q <= '0; pend_v_q <= 1'b0;
      out_q <= '0; out_v_q <= 1'b0;
    end else begin
      st_q <= st_d; ph_q <= ph_d;
      pt_cfg_q <= pt_cfg_d; win_q <= win_d; delay_q <= delay_d;
      kind_q <= kind_d; seq_q <= seq_d; ssrc_q <= ssrc_d; pt_q <= pt_d;
      hdl_q <= hdl_d; now_q <= now_d;
      exp_q <= exp_d; exp_known_q <= exp_known_d; src_q <= src_d;
      src_known_q <= src_known_d;
      cnt_q <= cnt_d;
      scan_q <= scan_d; scan_win_q <= scan_win_d; have_q <= have_d;
      best_q <= best_d; near_q <= near_d; oldest_q <= oldest_d;
      rcnt_q <= rcnt_d; pend_q <= pend_d; pend_v_q <= pend_v_d;
      out_q <= out_d; out_v_q <= out_v_d;
    end
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_q.handle, out_q.last_seq, out_q.first_seq, out_q.reason};
  assign m_axis_tuser  = out_q.rtype;
  assign m_axis_tlast  = out_q.tlast;

  `RSRB_ASSERT_NOW(a_idle_no_pend, s_axis_tready, !pend_v_q, "record left pending while idle")
  `RSRB_ASSERT_NOW(a_count_match, 1'b1, cnt_q == CntW'($countones(vld)), "held count drifted")
  `RSRB_ASSERT_NOW(a_unique_seq, 1'b1, $onehot0(hit_exp), "sequence held twice")
  `RSRB_ASSERT_NEXT(a_flush_done, (st_q == ST_FLUSH) && pend_v_q && out_free,
                    m_axis_tvalid && m_axis_tlast, "final record not marked")

endmodule

`default_nettype wire
